// ----- rtl/mbrb_pkg.sv -----
// Package for the monochrome rectangle blitter.
// Holds request/result structs, queue entry and shared constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mbrb_pkg;

  localparam int LEN_W = 8;
  localparam int POS_W = 17;
  localparam int BIDX_W = POS_W - 3;

  typedef enum logic [1:0] {
    OP_WR_SRC = 2'd0,
    OP_WR_TGT = 2'd1,
    OP_RD_TGT = 2'd2,
    OP_BLIT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_SRC_W = 2'd0,
    REG_TGT_W = 2'd1,
    REG_TGT_H = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [9:0] byte_address;
    logic [7:0] write_data;
    logic [6:0] src_left;
    logic [5:0] src_top;
    logic [7:0] src_right;
    logic [6:0] src_bottom;
    logic [6:0] dst_left;
    logic [5:0] dst_top;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       status;
  } res_t;

  typedef struct packed {
    op_t        op;
    logic [9:0] addr;
    logic [7:0] data;
    logic [6:0] sl;
    logic [5:0] st;
    logic [6:0] sb;
    logic [6:0] dl;
    logic [5:0] dt;
    logic [LEN_W-1:0] len;
  } entry_t;

endpackage
`default_nettype wire

// ----- rtl/mono_bitmap_rect_blit.sv -----
// Blit: rows are copied bit by bit; each target byte is read, then written back
//   through the single read-modify-write port of the target memory. Dropped rows
//   are skipped.
// A two-entry queue lets requests be taken while the engine works.
// Synchronous active-high reset clears control and config; bitmaps are not cleared.
// Depends on mbrb_pkg, mbrb_front, mbrb_queue, mbrb_back.
`timescale 1ns / 1ps
`default_nettype none
module mono_bitmap_rect_blit #(
  parameter int SOURCE_BYTES = 1024,
  parameter int TARGET_BYTES = 1024,
  parameter int MAX_ROW_BITS = 128
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_stall,
  input  mbrb_pkg::req_t  in_item,
  output logic            out_valid,
  input  wire             out_stall,
  output mbrb_pkg::res_t  out_item,
  input  wire             psel,
  input  wire             penable,
  input  wire             pwrite,
  input  wire  [3:0]      paddr,
  input  wire  [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import mbrb_pkg::*;

  logic [7:0] source_width;
  logic [7:0] target_width;
  logic [6:0] target_height;
  logic       q_full;
  logic       q_empty;
  logic       q_push;
  logic       q_pop;
  entry_t     q_wr;
  entry_t     q_rd;
  reg_idx_t   ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= 8'd128;
      target_width  <= 8'd128;
      target_height <= 7'd64;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_SRC_W: source_width  <= pwdata[7:0];
        REG_TGT_W: target_width  <= pwdata[7:0];
        REG_TGT_H: target_height <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_SRC_W: prdata = {24'd0, source_width};
      REG_TGT_W: prdata = {24'd0, target_width};
      REG_TGT_H: prdata = {25'd0, target_height};
      default:   prdata = 32'd0;
    endcase
  end

  mbrb_front #(.MAX_ROW_BITS(MAX_ROW_BITS)) u_front (
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .target_width(target_width), .q_full(q_full), .q_push(q_push), .q_entry(q_wr)
  );

  mbrb_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .wr_entry(q_wr), .pop(q_pop),
    .rd_entry(q_rd), .full(q_full), .empty(q_empty)
  );

  mbrb_back #(.SOURCE_BYTES(SOURCE_BYTES), .TARGET_BYTES(TARGET_BYTES)) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_entry(q_rd), .q_pop(q_pop),
    .source_width(source_width), .target_width(target_width),
    .target_height(target_height), .out_valid(out_valid), .out_stall(out_stall),
    .out_item(out_item)
  );

endmodule
`default_nettype wire

// ----- rtl/mbrb_front.sv -----
// Front end: accepts requests, clips the row length and pushes queue entries.
// Depends on mbrb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mbrb_front #(
  parameter int MAX_ROW_BITS = 128
) (
  input  wire              in_valid,
  output logic             in_stall,
  input  mbrb_pkg::req_t   in_item,
  input  wire  [7:0]       target_width,
  input  wire              q_full,
  output logic             q_push,
  output mbrb_pkg::entry_t q_entry
);
  import mbrb_pkg::*;

  logic [7:0] span;
  logic [7:0] room;
  logic [7:0] len;

  always_comb begin
    span = in_item.src_right - {1'b0, in_item.src_left};
    room = target_width - {1'b0, in_item.dst_left};
    len  = '0;
    if (in_item.src_right > {1'b0, in_item.src_left} && target_width > {1'b0, in_item.dst_left}) begin
      len = (span < room) ? span : room;
      if (32'(len) > MAX_ROW_BITS) begin
        len = 8'(MAX_ROW_BITS);
      end
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

  always_comb begin
    q_entry.op   = op_t'(in_item.operation);
    q_entry.addr = in_item.byte_address;
    q_entry.data = in_item.write_data;
    q_entry.sl   = in_item.src_left;
    q_entry.st   = in_item.src_top;
    q_entry.sb   = in_item.src_bottom;
    q_entry.dl   = in_item.dst_left;
    q_entry.dt   = in_item.dst_top;
    q_entry.len  = len;
  end

endmodule
`default_nettype wire

// ----- rtl/mbrb_queue.sv -----
// Two-entry request queue between front and back ends.
// Depends on mbrb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mbrb_queue (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  mbrb_pkg::entry_t wr_entry,
  input  wire              pop,
  output mbrb_pkg::entry_t rd_entry,
  output logic             full,
  output logic             empty
);
  import mbrb_pkg::*;

  entry_t     slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign rd_entry = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mbrb_back.sv -----
// Back end: source and target bitmap memories, bit-by-bit blit engine and result register.
// Depends on mbrb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mbrb_back #(
  parameter int SOURCE_BYTES = 1024,
  parameter int TARGET_BYTES = 1024
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              q_empty,
  input  mbrb_pkg::entry_t q_entry,
  output logic             q_pop,
  input  wire  [7:0]       source_width,
  input  wire  [7:0]       target_width,
  input  wire  [6:0]       target_height,
  output logic             out_valid,
  input  wire              out_stall,
  output mbrb_pkg::res_t   out_item
);
  import mbrb_pkg::*;

  localparam int SAW = (SOURCE_BYTES > 1) ? $clog2(SOURCE_BYTES) : 1;
  localparam int TAW = (TARGET_BYTES > 1) ? $clog2(TARGET_BYTES) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_ROW  = 6'b000100,
    S_RD   = 6'b001000,
    S_WR   = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t           state;
  entry_t           cur;
  logic [6:0]       srow;
  logic [7:0]       trow;
  logic [POS_W-1:0] sp;
  logic [POS_W-1:0] tp;
  logic [LEN_W-1:0] cnt;
  logic             status;

  logic [7:0] src_mem [SOURCE_BYTES];
  logic [7:0] tgt_mem [TARGET_BYTES];
  logic [7:0] sbyte;
  logic [7:0] tbyte;
  logic       s_ok;
  logic       t_ok;

  logic             blit;
  logic [BIDX_W-1:0] sidx;
  logic [BIDX_W-1:0] tidx;
  logic             sidx_ok;
  logic             tidx_ok;
  logic [2:0]       tbit;
  logic [2:0]       sbit_sel;
  logic [7:0]       mask;
  logic             sbit;
  logic [7:0]       tnew;
  logic             src_we;
  logic             tgt_we;
  logic [7:0]       tgt_wd;
  logic             res_load;

  assign blit     = (cur.op == OP_BLIT);
  assign sidx     = blit ? sp[POS_W-1:3] : BIDX_W'(cur.addr);
  assign tidx     = blit ? tp[POS_W-1:3] : BIDX_W'(cur.addr);
  assign sidx_ok  = (32'(sidx) < SOURCE_BYTES);
  assign tidx_ok  = (32'(tidx) < TARGET_BYTES);
  assign tbit     = tp[2:0];
  assign sbit_sel = 3'd7 - sp[2:0];
  assign mask     = 8'h80 >> tbit;
  assign sbit     = s_ok & sbyte[sbit_sel];
  assign tnew     = (tbyte & ~mask) | (sbit ? mask : 8'h00);

  assign src_we = (state == S_EXEC) && (cur.op == OP_WR_SRC) && sidx_ok;
  assign tgt_we = ((state == S_EXEC) && (cur.op == OP_WR_TGT) && tidx_ok)
               || ((state == S_WR) && t_ok);
  assign tgt_wd = (state == S_WR) ? tnew : cur.data;

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign res_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (src_we) begin
      src_mem[sidx[SAW-1:0]] <= cur.data;
    end
    sbyte <= src_mem[sidx[SAW-1:0]];
    s_ok  <= sidx_ok;
  end

  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[tidx[TAW-1:0]] <= tgt_wd;
    end
    tbyte <= tgt_mem[tidx[TAW-1:0]];
    t_ok  <= tidx_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            state <= (q_entry.op == OP_BLIT) ? S_ROW : S_EXEC;
          end
        end
        S_EXEC: begin
          state <= (cur.op == OP_RD_TGT) ? S_RD : S_DONE;
        end
        S_ROW: begin
          if (srow >= cur.sb) begin
            state <= S_DONE;
          end else if (trow < {1'b0, target_height} && cur.len != '0) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= blit ? S_WR : S_DONE;
        end
        S_WR: begin
          state <= (cnt + LEN_W'(1) == cur.len) ? S_ROW : S_RD;
        end
        S_DONE: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur    <= q_entry;
        srow   <= {1'b0, q_entry.st};
        trow   <= {2'b00, q_entry.dt};
        status <= 1'b0;
      end
      S_ROW: begin
        cnt <= '0;
        sp  <= POS_W'(cur.sl) + POS_W'(srow) * POS_W'(source_width);
        tp  <= POS_W'(cur.dl) + POS_W'(trow) * POS_W'(target_width);
        if (srow < cur.sb) begin
          if (trow >= {1'b0, target_height}) begin
            status <= 1'b1;
            srow   <= srow + 7'd1;
            trow   <= trow + 8'd1;
          end else if (cur.len == '0) begin
            srow <= srow + 7'd1;
            trow <= trow + 8'd1;
          end
        end
      end
      S_WR: begin
        cnt <= cnt + LEN_W'(1);
        sp  <= sp + POS_W'(1);
        tp  <= tp + POS_W'(1);
        if (cnt + LEN_W'(1) == cur.len) begin
          srow <= srow + 7'd1;
          trow <= trow + 8'd1;
        end
      end
      default: begin
      end
    endcase
    if (res_load) begin
      out_item.status    <= blit & status;
      out_item.read_data <= ((cur.op == OP_RD_TGT) && t_ok) ? tbyte : 8'h00;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mbrb_checker.sv -----
// Port-level checker for the blitter, bound to the top level.
// Depends on mbrb_pkg and mono_bitmap_rect_blit.
`timescale 1ns / 1ps
`default_nettype none
module mbrb_checker (
  input wire             clk,
  input wire             rst,
  input wire             out_valid,
  input wire             out_stall,
  input mbrb_pkg::res_t  out_item,
  input wire             psel,
  input wire             penable,
  input wire             pwrite,
  input wire [3:0]       paddr,
  input wire [31:0]      pwdata,
  input wire [31:0]      prdata
);
  import mbrb_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_item))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_status_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status |-> out_item.read_data == 8'h00)
    else $error("dropped-row status with read data");

  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr == 4'd0 ##1 paddr == 4'd0
      |-> prdata[7:0] == $past(pwdata[7:0]))
    else $error("source width readback mismatch");

endmodule

bind mono_bitmap_rect_blit mbrb_checker u_mbrb_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .out_item(out_item), .psel(psel), .penable(penable), .pwrite(pwrite),
  .paddr(paddr), .pwdata(pwdata), .prdata(prdata)
);
`default_nettype wire
